FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: hw/rtl/lssd_pkg.sv
// ----------------------------------------------------------------------------
// lssd_pkg
// Types and constants shared by the scan sample deframer modules.
// ----------------------------------------------------------------------------
package lssd_pkg;

  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int QUAL_W    = 6;
  localparam int ANGLE_W   = 15;
  localparam int DIST_W    = 16;
  localparam int REV_W     = 16;
  localparam int MATCH_W   = 3;
  localparam int DESC_LEN  = 7;
  localparam int SMP_LEN   = 5;
  localparam int QDEPTH    = 2;

  localparam logic [BYTE_W-1:0] DESC_B0 = 8'hA5;
  localparam logic [BYTE_W-1:0] DESC_B1 = 8'h5A;
  localparam logic [BYTE_W-1:0] DESC_B2 = 8'h05;
  localparam logic [BYTE_W-1:0] DESC_B3 = 8'h00;
  localparam logic [BYTE_W-1:0] DESC_B4 = 8'h00;
  localparam logic [BYTE_W-1:0] DESC_B5 = 8'h40;
  localparam logic [BYTE_W-1:0] DESC_B6 = 8'h81;

  localparam logic [MATCH_W-1:0] MATCH_FULL = 3'd7;
  localparam logic [MATCH_W-1:0] DESC_LAST  = 3'd6;
  localparam logic [MATCH_W-1:0] SMP_LAST   = 3'd4;

  typedef enum logic [1:0] {
    PH_DESC   = 2'd0,
    PH_SAMPLE = 2'd1,
    PH_HALT   = 2'd2
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DESC_OK  = 2'd0,
    ST_SMP_OK   = 2'd1,
    ST_SMP_BAD  = 2'd2,
    ST_DESC_BAD = 2'd3
  } status_e;

  // One classified record passed from the front to the back.
  typedef struct packed {
    logic                 restart;
    status_e              status;
    logic                 sos;
    logic [QUAL_W-1:0]    quality;
    logic [ANGLE_W-1:0]   angle;
    logic [DIST_W-1:0]    distance;
    logic [MATCH_W-1:0]   matched;
  } entry_t;

  // Queue status seen by its neighbours.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [BYTE_W-1:0] desc_byte(input logic [MATCH_W-1:0] pos);
    logic [BYTE_W-1:0] b;
    case (pos)
      3'd0:    b = DESC_B0;
      3'd1:    b = DESC_B1;
      3'd2:    b = DESC_B2;
      3'd3:    b = DESC_B3;
      3'd4:    b = DESC_B4;
      3'd5:    b = DESC_B5;
      default: b = DESC_B6;
    endcase
    return b;
  endfunction

endpackage

FILE: hw/rtl/lssd_front.sv
// ----------------------------------------------------------------------------
// lssd_front
// Matches the response descriptor, gathers sample bytes and classifies.
// ----------------------------------------------------------------------------
module lssd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        beat_i,
  input  logic [lssd_pkg::BYTE_W-1:0] rx_byte_i,
  input  logic                        restart_i,
  output logic                        push_o,
  output lssd_pkg::entry_t            entry_o
);

  lssd_pkg::phase_e              phase_q, phase_d;
  logic [lssd_pkg::MATCH_W-1:0]  pos_q, pos_d;
  logic [lssd_pkg::BYTE_W-1:0]   smp_q [4];
  logic [lssd_pkg::MATCH_W-1:0]  desc_pos;
  logic                          desc_hit;
  logic                          smp_valid;

  // Position is clamped onto the last descriptor byte.
  assign desc_pos  = (pos_q > lssd_pkg::DESC_LAST) ? lssd_pkg::DESC_LAST : pos_q;
  assign desc_hit  = (rx_byte_i == lssd_pkg::desc_byte(desc_pos));
  assign smp_valid = (smp_q[0][0] ^ smp_q[0][1]) & smp_q[1][0];

  // Next state.
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    if (beat_i) begin
      if (restart_i) begin
        phase_d = lssd_pkg::PH_DESC;
        pos_d   = '0;
      end else begin
        unique case (phase_q)
          lssd_pkg::PH_DESC: begin
            if (!desc_hit) begin
              phase_d = lssd_pkg::PH_HALT;
              pos_d   = '0;
            end else if (desc_pos == lssd_pkg::DESC_LAST) begin
              phase_d = lssd_pkg::PH_SAMPLE;
              pos_d   = '0;
            end else begin
              pos_d = desc_pos + 3'd1;
            end
          end
          lssd_pkg::PH_SAMPLE: begin
            if (pos_q < lssd_pkg::SMP_LAST) begin
              pos_d = pos_q + 3'd1;
            end else begin
              pos_d = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Outputs: the record pushed for this beat.
  always_comb begin
    push_o  = 1'b0;
    entry_o = '{restart: 1'b0, status: lssd_pkg::ST_DESC_OK, sos: 1'b0,
                quality: '0, angle: '0, distance: '0, matched: lssd_pkg::MATCH_FULL};
    if (beat_i) begin
      if (restart_i) begin
        push_o          = 1'b1;
        entry_o.restart = 1'b1;
      end else begin
        unique case (phase_q)
          lssd_pkg::PH_DESC: begin
            if (!desc_hit) begin
              push_o          = 1'b1;
              entry_o.status  = lssd_pkg::ST_DESC_BAD;
              entry_o.matched = desc_pos;
            end else if (desc_pos == lssd_pkg::DESC_LAST) begin
              push_o = 1'b1;
            end
          end
          lssd_pkg::PH_SAMPLE: begin
            if (pos_q >= lssd_pkg::SMP_LAST) begin
              push_o = 1'b1;
              if (smp_valid) begin
                entry_o.status   = lssd_pkg::ST_SMP_OK;
                entry_o.sos      = smp_q[0][0];
                entry_o.quality  = smp_q[0][7:2];
                entry_o.angle    = {smp_q[2], smp_q[1][7:1]};
                entry_o.distance = {rx_byte_i, smp_q[3]};
              end else begin
                entry_o.status = lssd_pkg::ST_SMP_BAD;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lssd_pkg::PH_DESC;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

  // Sample bytes are payload; each is written before the check reads it.
  always_ff @(posedge clk_i) begin
    if (beat_i && !restart_i && phase_q == lssd_pkg::PH_SAMPLE
        && pos_q < lssd_pkg::SMP_LAST) begin
      smp_q[pos_q[1:0]] <= rx_byte_i;
    end
  end

endmodule

FILE: hw/rtl/lssd_queue.sv
// ----------------------------------------------------------------------------
// lssd_queue
// Short first-in first-out queue of classified records.
// ----------------------------------------------------------------------------
module lssd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lssd_pkg::entry_t    wdata_i,
  input  logic                pop_i,
  output lssd_pkg::entry_t    rdata_o,
  output lssd_pkg::q_status_t status_o
);

  localparam int AW = $clog2(lssd_pkg::QDEPTH);
  localparam int CW = $clog2(lssd_pkg::QDEPTH + 1);

  lssd_pkg::entry_t mem_q [lssd_pkg::QDEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == CW'(lssd_pkg::QDEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign rdata_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(lssd_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(lssd_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: hw/rtl/lssd_back.sv
// ----------------------------------------------------------------------------
// lssd_back
// Counts revolutions and holds the result register towards the consumer.
// ----------------------------------------------------------------------------
module lssd_back #(
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lssd_pkg::entry_t              entry_i,
  input  lssd_pkg::q_status_t           q_status_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lssd_pkg::STATUS_W-1:0] status_o,
  output logic                          start_of_scan_o,
  output logic [lssd_pkg::QUAL_W-1:0]   quality_o,
  output logic [lssd_pkg::ANGLE_W-1:0]  angle_q6_o,
  output logic [lssd_pkg::DIST_W-1:0]   distance_q2_o,
  output logic [lssd_pkg::REV_W-1:0]    revolutions_o,
  output logic [lssd_pkg::MATCH_W-1:0]  matched_count_o
);

  logic [COUNT_BITS-1:0]      count_q, count_d;
  logic [lssd_pkg::REV_W-1:0] rev_shown;
  logic                       valid_q, valid_d;
  lssd_pkg::entry_t           res_q;
  logic [lssd_pkg::REV_W-1:0] rev_q;
  logic                       load;

  assign pop_o = !q_status_i.empty && (!valid_q || !out_stall_i);
  assign load  = pop_o && !entry_i.restart;

  always_comb begin
    count_d = count_q;
    if (pop_o) begin
      if (entry_i.restart) begin
        count_d = '0;
      end else if (entry_i.status == lssd_pkg::ST_SMP_OK && entry_i.sos && !(&count_q)) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  // The count is shown saturated at the width of the result field.
  generate
    if (COUNT_BITS > lssd_pkg::REV_W) begin : g_clip
      assign rev_shown = (|count_d[COUNT_BITS-1:lssd_pkg::REV_W]) ? '1
                                                                 : count_d[lssd_pkg::REV_W-1:0];
    end else begin : g_ext
      assign rev_shown = lssd_pkg::REV_W'(count_d);
    end
  endgenerate

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = !entry_i.restart;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= entry_i;
      rev_q <= rev_shown;
    end
  end

  assign out_valid_o     = valid_q;
  assign status_o        = res_q.status;
  assign start_of_scan_o = res_q.sos;
  assign quality_o       = res_q.quality;
  assign angle_q6_o      = res_q.angle;
  assign distance_q2_o   = res_q.distance;
  assign revolutions_o   = rev_q;
  assign matched_count_o = res_q.matched;

endmodule

FILE: hw/rtl/lidar_scan_sample_deframer.sv
// ----------------------------------------------------------------------------
// lidar_scan_sample_deframer
// Deframes a scanner's scan reply into descriptor and sample results.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------
//   in      | sink      | in_valid_i/in_stall_o  | rx_byte_i, restart_i
//   out     | source    | out_valid_o/out_stall_i| status, start_of_scan, ...
//
// One byte beat is taken in every cycle while the record queue has room;
// the beat that completes a result writes its record into the queue, from
// where the back loads it into the output register, and the front keeps
// taking bytes while that result waits.
// The rate is set by the front's combinational classification and the
// back's drain of one record per cycle while the output is not stalled.
// Reset clears the phase, the byte position, the queue and the revolution
// count; the block is ready as soon as reset is released.
// A stalled output fills the two-entry queue, after which in_stall_o rises.
//
// The front compares each byte against the expected descriptor byte, then
// gathers four sample bytes and checks the fifth-beat sample. Every beat
// that yields a result, and every restart beat, places one record in the
// queue. The back applies restarts to the revolution count in stream order,
// so a restart never clears the count ahead of results still waiting.
module lidar_scan_sample_deframer #(
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lssd_pkg::BYTE_W-1:0]   rx_byte_i,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lssd_pkg::STATUS_W-1:0] status_o,
  output logic                          start_of_scan_o,
  output logic [lssd_pkg::QUAL_W-1:0]   quality_o,
  output logic [lssd_pkg::ANGLE_W-1:0]  angle_q6_o,
  output logic [lssd_pkg::DIST_W-1:0]   distance_q2_o,
  output logic [lssd_pkg::REV_W-1:0]    revolutions_o,
  output logic [lssd_pkg::MATCH_W-1:0]  matched_count_o
);

  logic                beat;
  logic                push;
  logic                pop;
  lssd_pkg::entry_t    wr_entry;
  lssd_pkg::entry_t    rd_entry;
  lssd_pkg::q_status_t q_status;

  // The stall is taken from the queue's full flag alone, so a beat is never
  // accepted without room for the record it may produce.
  assign in_stall_o = q_status.full;
  assign beat       = in_valid_i && !in_stall_o;

  lssd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .rx_byte_i (rx_byte_i),
    .restart_i (restart_i),
    .push_o    (push),
    .entry_o   (wr_entry)
  );

  lssd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (wr_entry),
    .pop_i    (pop),
    .rdata_o  (rd_entry),
    .status_o (q_status)
  );

  lssd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entry_i         (rd_entry),
    .q_status_i      (q_status),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .start_of_scan_o (start_of_scan_o),
    .quality_o       (quality_o),
    .angle_q6_o      (angle_q6_o),
    .distance_q2_o   (distance_q2_o),
    .revolutions_o   (revolutions_o),
    .matched_count_o (matched_count_o)
  );

endmodule

FILE: hw/rtl/lssd_checker.sv
// ----------------------------------------------------------------------------
// lssd_checker
// Port-level checks of the deframer's result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lssd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_stall_i,
  input logic [lssd_pkg::STATUS_W-1:0] status_i,
  input logic                          start_of_scan_i,
  input logic [lssd_pkg::QUAL_W-1:0]   quality_i,
  input logic [lssd_pkg::ANGLE_W-1:0]  angle_q6_i,
  input logic [lssd_pkg::DIST_W-1:0]   distance_q2_i,
  input logic [lssd_pkg::MATCH_W-1:0]  matched_count_i
);

  logic no_sample;

  assign no_sample = !start_of_scan_i && (quality_i == '0) && (angle_q6_i == '0)
                     && (distance_q2_i == '0);

  // A stalled result beat stays offered, with its status and distance unchanged.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i,
               out_valid_i && $stable(status_i) && $stable(distance_q2_i))

  // A completed descriptor reports all seven bytes and no sample data.
  `ASSERT_IMPLY(a_desc_ok, clk_i, rst_ni, out_valid_i && status_i == lssd_pkg::ST_DESC_OK,
                matched_count_i == lssd_pkg::MATCH_FULL && no_sample)

  // A mismatch always stops short of the full descriptor.
  `ASSERT_IMPLY(a_desc_bad, clk_i, rst_ni, out_valid_i && status_i == lssd_pkg::ST_DESC_BAD,
                matched_count_i != lssd_pkg::MATCH_FULL && no_sample)

  // A failed sample carries no measurement.
  `ASSERT_IMPLY(a_smp_bad, clk_i, rst_ni, out_valid_i && status_i == lssd_pkg::ST_SMP_BAD,
                matched_count_i == lssd_pkg::MATCH_FULL && no_sample)

endmodule

bind lidar_scan_sample_deframer lssd_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_i        (status_o),
  .start_of_scan_i (start_of_scan_o),
  .quality_i       (quality_o),
  .angle_q6_i      (angle_q6_o),
  .distance_q2_i   (distance_q2_o),
  .matched_count_i (matched_count_o)
);
